// ===== hw/rtl/kplp_pkg.sv =====
package kplp_pkg;

  localparam int unsigned KeyCount = 6;
  localparam int unsigned CountW   = 8;
  localparam int unsigned EventW   = 5;

  typedef logic [KeyCount-1:0] key_mask_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [EventW-1:0]   event_t;

  // one-hot key masks
  localparam key_mask_t KeyNone  = 6'h00;
  localparam key_mask_t KeyBack  = 6'h01;
  localparam key_mask_t KeyLeft  = 6'h02;
  localparam key_mask_t KeyUp    = 6'h04;
  localparam key_mask_t KeyDown  = 6'h08;
  localparam key_mask_t KeyRight = 6'h10;
  localparam key_mask_t KeyEnter = 6'h20;

  // event codes: press 1..6, release +6, long press +12
  localparam event_t EvNone       = 5'd0;
  localparam event_t EvUp         = 5'd1;
  localparam event_t EvDown       = 5'd2;
  localparam event_t EvLeft       = 5'd3;
  localparam event_t EvRight      = 5'd4;
  localparam event_t EvEnter      = 5'd5;
  localparam event_t EvBack       = 5'd6;
  localparam event_t EvReleaseOfs = 5'd6;
  localparam event_t EvLongOfs    = 5'd12;
  localparam event_t EvMax        = 5'd18;

  localparam count_t LongTicksReset = 8'd50;
  localparam count_t CountMax       = 8'd255;

  // input register contents handed to the state machine
  typedef struct packed {
    logic      valid;
    key_mask_t pins;
  } in_stage_t;

  // fixed priority: left, back, down, up, enter, right
  function automatic key_mask_t pick_key(key_mask_t pins);
    key_mask_t down;
    key_mask_t pick;
    down = ~pins;
    if ((down & KeyLeft) != KeyNone) begin
      pick = KeyLeft;
    end else if ((down & KeyBack) != KeyNone) begin
      pick = KeyBack;
    end else if ((down & KeyDown) != KeyNone) begin
      pick = KeyDown;
    end else if ((down & KeyUp) != KeyNone) begin
      pick = KeyUp;
    end else if ((down & KeyEnter) != KeyNone) begin
      pick = KeyEnter;
    end else if ((down & KeyRight) != KeyNone) begin
      pick = KeyRight;
    end else begin
      pick = KeyNone;
    end
    return pick;
  endfunction

  function automatic event_t coded(key_mask_t mask, event_t offset);
    event_t base;
    unique case (mask)
      KeyBack:  base = EvBack;
      KeyEnter: base = EvEnter;
      KeyUp:    base = EvUp;
      KeyDown:  base = EvDown;
      KeyLeft:  base = EvLeft;
      KeyRight: base = EvRight;
      default:  base = EvNone;
    endcase
    return (base == EvNone) ? EvNone : event_t'(base + offset);
  endfunction

endpackage

// ===== hw/rtl/kplp_in.sv =====
module kplp_in import kplp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  key_mask_t key_pins,
  input  logic      advance,
  output logic      in_stall,
  output in_stage_t stage
);

  // holds while its item cannot move on
  assign in_stall = stage.valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (!in_stall) begin
      stage.valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      stage.pins <= key_pins;
    end
  end

endmodule

// ===== hw/rtl/kplp_fsm.sv =====
module kplp_fsm import kplp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_stage_t stage,
  input  count_t    long_press_ticks,
  output event_t    ev
);

  typedef enum logic [2:0] {
    IDLE         = 3'd0,
    PRESS_SEEN   = 3'd1,
    HELD         = 3'd2,
    RELEASE_SEEN = 3'd3,
    LONG_HELD    = 3'd4,
    LONG_RELEASE = 3'd5,
    PRESS_REPORT = 3'd6
  } phase_t;

  phase_t    phase, phase_next;
  count_t    hold_count, hold_count_next;
  key_mask_t held_key, held_key_next;
  key_mask_t key;
  count_t    count_inc;

  assign key       = pick_key(stage.pins);
  assign count_inc = (hold_count == CountMax) ? hold_count : count_t'(hold_count + 1'b1);

  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_count;
    held_key_next   = held_key;
    ev              = EvNone;
    unique case (phase)
      IDLE: begin
        if (key != KeyNone) begin
          phase_next      = PRESS_SEEN;
          hold_count_next = '0;
          held_key_next   = KeyNone;
        end
      end
      PRESS_SEEN: begin
        if (key != KeyNone) begin
          phase_next      = HELD;
          hold_count_next = count_inc;
          held_key_next   = key;
        end else begin
          phase_next = IDLE;
        end
      end
      HELD: begin
        if (key != KeyNone) begin
          hold_count_next = count_inc;
          if (count_inc > long_press_ticks) begin
            phase_next      = LONG_HELD;
            hold_count_next = long_press_ticks;
            held_key_next   = key;
            ev              = coded(key, EvLongOfs);
          end
        end else begin
          phase_next = RELEASE_SEEN;
        end
      end
      RELEASE_SEEN: begin
        if (key == KeyNone) begin
          hold_count_next = '0;
          phase_next      = PRESS_REPORT;
          ev              = coded(held_key, EvReleaseOfs);
        end else begin
          phase_next = HELD;
        end
      end
      LONG_HELD: begin
        if (key == KeyNone) begin
          phase_next = LONG_RELEASE;
        end
      end
      LONG_RELEASE: begin
        if (key == KeyNone) begin
          hold_count_next = '0;
          phase_next      = IDLE;
          ev              = coded(held_key, EvReleaseOfs);
        end else begin
          phase_next = LONG_HELD;
        end
      end
      PRESS_REPORT: begin
        phase_next = IDLE;
        ev         = coded(held_key, EvNone);
      end
      default: begin
        phase_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= IDLE;
      hold_count <= '0;
      held_key   <= KeyNone;
    end else if (advance) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
      held_key   <= held_key_next;
    end
  end

endmodule

// ===== hw/rtl/kplp_out.sv =====
module kplp_out import kplp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  event_t ev,
  input  logic   out_stall,
  output logic   out_valid,
  output event_t event_code
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      event_code <= ev;
    end
  end

endmodule

// ===== hw/rtl/key_press_long_press_detector_top.sv =====
// Key scanner with press confirmation, long-press and release reporting.
//
// Input channel (in_valid / in_stall / key_pins): one transaction per scan
// tick, key_pins active low, bit i = key i. Output channel (out_valid /
// out_stall / event_code): exactly one transaction per input transaction,
// in order; event_code 0 means nothing happened on that tick.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes long_press_ticks;
// cfg_ready is always high. Write only while no item is in flight.
//
// An accepted item waits in the input register; the state update and event
// decode then feed the result register, which raises out_valid.
// Throughput: one item per cycle; the state machine step is a single pass of
// logic between the two registers, so the input register drains whenever the
// result register is empty or being taken in the same cycle.
//
// Reset (rst, synchronous): both registers empty, machine idle, hold count
// and held key cleared, long_press_ticks back to 50.
// Output stall: result and its code hold; the input register keeps one item
// and in_stall rises once it is full behind the stalled result.
module key_press_long_press_detector_top import kplp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  key_mask_t key_pins,
  output logic      out_valid,
  input  logic      out_stall,
  output event_t    event_code,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  count_t    cfg_data
);

  in_stage_t stage;
  event_t    ev;
  logic      advance;
  count_t    long_press_ticks;

  // item moves from input register into result register
  assign advance   = stage.valid && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LongTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      long_press_ticks <= cfg_data;
    end
  end

  kplp_in u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .key_pins (key_pins),
    .advance  (advance),
    .in_stall (in_stall),
    .stage    (stage)
  );

  kplp_fsm u_fsm (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .stage            (stage),
    .long_press_ticks (long_press_ticks),
    .ev               (ev)
  );

  kplp_out u_out (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ev         (ev),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .event_code (event_code)
  );

endmodule

// ===== hw/rtl/kplp_checker.sv =====
module kplp_checker import kplp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input event_t    event_code
);

  // codes stay in the defined range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= EvMax)
    else $error("event_code out of range");

  // input only blocks behind a stalled result
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without stalled output");

  // accepted item reaches the output if the path is clear
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after accepted item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(event_code)))
    else $error("stalled result changed");

endmodule

bind key_press_long_press_detector_top kplp_checker u_kplp_checker (.*);
